### hdl/gprmc_sentence_field_extractor_macros.svh
// Assertion macros shared by the GPRMC extractor RTL
`ifndef GPRMC_SENTENCE_FIELD_EXTRACTOR_MACROS_SVH
`define GPRMC_SENTENCE_FIELD_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GPRMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define GPRMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gprmc_pkg.sv
// Types and constants of the GPRMC sentence field extractor
package gprmc_pkg;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_HUNT1  = 4'b0001,
        PH_HUNT2  = 4'b0010,
        PH_HEADER = 4'b0100,
        PH_LINE   = 4'b1000
    } phase_t;

    // Fix letter seen in the status field
    typedef enum logic [1:0] {
        FIX_UNKNOWN = 2'd0,
        FIX_A       = 2'd1,
        FIX_V       = 2'd2,
        FIX_OTHER   = 2'd3
    } fix_t;

    // Sentence status codes
    localparam logic [1:0] ST_VALID  = 2'd0;
    localparam logic [1:0] ST_NO_END = 2'd1;
    localparam logic [1:0] ST_HEADER = 2'd2;
    localparam logic [1:0] ST_VOID   = 2'd3;

    // Result kinds
    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Characters of interest
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_V      = 8'h56;

    // Talker and sentence id following the second dollar sign
    localparam int unsigned HDR_LEN = 5;
    localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

    // Field counter
    localparam logic [3:0] FIELD_MAX   = 4'd15;
    localparam logic [3:0] FIELD_TIME  = 4'd1;
    localparam logic [3:0] FIELD_STAT  = 4'd2;
    localparam logic [3:0] FIELD_LAT   = 4'd3;
    localparam logic [3:0] FIELD_EW    = 4'd6;

    localparam logic [2:0] FNUM_TIME = 3'd0;
    localparam logic [2:0] FNUM_STAT = 3'd1;

    localparam logic [7:0] SEARCH_LIMIT_RESET = 8'd101;

    // One result request
    typedef struct packed {
        logic       kind;
        logic [2:0] field_number;
        logic [7:0] char_value;
        logic [1:0] status;
    } result_t;

endpackage

### hdl/gprmc_step.sv
// Parser state and per-byte step logic of the GPRMC extractor
module gprmc_step #(
    parameter int MAX_LINE_BYTES = 85
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic [7:0]             rx_byte,
    input  logic [7:0]             search_limit,
    output logic                   has_result,
    output gprmc_pkg::result_t     result
);

    localparam int LINE_W = $clog2(MAX_LINE_BYTES);
    localparam logic [LINE_W:0] LINE_LIMIT = (LINE_W + 1)'(MAX_LINE_BYTES);

    gprmc_pkg::phase_t phase_reg, phase_next;
    gprmc_pkg::fix_t   fix_reg, fix_next;
    logic [7:0]        search_count_reg, search_count_next;
    logic [2:0]        hdr_pos_reg, hdr_pos_next;
    logic              mismatch_reg, mismatch_next;
    logic [LINE_W-1:0] line_count_reg, line_count_next;
    logic [3:0]        field_index_reg, field_index_next;

    logic [2:0]        hdr_sel;
    logic              mismatch_upd;
    logic [LINE_W:0]   line_inc;
    logic              done;
    logic [1:0]        done_status;

    // Step for the byte at the head of the pipe
    always_comb
    begin
        phase_next        = phase_reg;
        fix_next          = fix_reg;
        search_count_next = search_count_reg;
        hdr_pos_next      = hdr_pos_reg;
        mismatch_next     = mismatch_reg;
        line_count_next   = line_count_reg;
        field_index_next  = field_index_reg;
        has_result        = 1'b0;
        result            = '0;
        done              = 1'b0;
        done_status       = gprmc_pkg::ST_VALID;
        hdr_sel           = (hdr_pos_reg < 3'(gprmc_pkg::HDR_LEN)) ? hdr_pos_reg
                            : 3'(gprmc_pkg::HDR_LEN - 1);
        mismatch_upd      = mismatch_reg || (rx_byte != gprmc_pkg::HDR_TEXT[hdr_sel]);
        line_inc          = (LINE_W + 1)'(line_count_reg) + (LINE_W + 1)'(1);

        case (phase_reg)
            gprmc_pkg::PH_HUNT1,
            gprmc_pkg::PH_HUNT2:
            begin
                if (search_count_reg >= search_limit)
                begin
                    done        = 1'b1;
                    done_status = gprmc_pkg::ST_HEADER;
                end
                else if (rx_byte == gprmc_pkg::CH_DOLLAR)
                begin
                    search_count_next = '0;
                    if (phase_reg == gprmc_pkg::PH_HUNT1)
                    begin
                        phase_next = gprmc_pkg::PH_HUNT2;
                    end
                    else
                    begin
                        phase_next    = gprmc_pkg::PH_HEADER;
                        hdr_pos_next  = '0;
                        mismatch_next = 1'b0;
                    end
                end
                else
                begin
                    search_count_next = search_count_reg + 8'd1;
                end
            end

            gprmc_pkg::PH_HEADER:
            begin
                mismatch_next = mismatch_upd;
                hdr_pos_next  = hdr_pos_reg + 3'd1;
                if (hdr_pos_next >= 3'(gprmc_pkg::HDR_LEN))
                begin
                    if (mismatch_upd)
                    begin
                        done        = 1'b1;
                        done_status = gprmc_pkg::ST_HEADER;
                    end
                    else
                    begin
                        phase_next       = gprmc_pkg::PH_LINE;
                        line_count_next  = '0;
                        field_index_next = '0;
                        fix_next         = gprmc_pkg::FIX_UNKNOWN;
                    end
                end
            end

            gprmc_pkg::PH_LINE:
            begin
                if (rx_byte inside {gprmc_pkg::CH_LF, gprmc_pkg::CH_CR})
                begin
                    done        = 1'b1;
                    done_status = (fix_reg == gprmc_pkg::FIX_V
                                   && field_index_reg >= gprmc_pkg::FIELD_EW)
                                  ? gprmc_pkg::ST_VOID : gprmc_pkg::ST_VALID;
                end
                else if (line_inc >= LINE_LIMIT)
                begin
                    done        = 1'b1;
                    done_status = gprmc_pkg::ST_NO_END;
                end
                else
                begin
                    line_count_next = line_inc[LINE_W-1:0];
                    if (rx_byte == gprmc_pkg::CH_COMMA)
                    begin
                        if (field_index_reg != gprmc_pkg::FIELD_MAX)
                            field_index_next = field_index_reg + 4'd1;
                    end
                    else if (field_index_reg == gprmc_pkg::FIELD_TIME)
                    begin
                        has_result          = 1'b1;
                        result.kind         = gprmc_pkg::KIND_CHAR;
                        result.field_number = gprmc_pkg::FNUM_TIME;
                        result.char_value   = rx_byte;
                    end
                    else if (field_index_reg == gprmc_pkg::FIELD_STAT)
                    begin
                        // first status letter sets the fix
                        if (fix_reg == gprmc_pkg::FIX_UNKNOWN)
                        begin
                            if (rx_byte == gprmc_pkg::CH_A)
                                fix_next = gprmc_pkg::FIX_A;
                            else if (rx_byte == gprmc_pkg::CH_V)
                                fix_next = gprmc_pkg::FIX_V;
                            else
                                fix_next = gprmc_pkg::FIX_OTHER;
                        end
                        has_result          = 1'b1;
                        result.kind         = gprmc_pkg::KIND_CHAR;
                        result.field_number = gprmc_pkg::FNUM_STAT;
                        result.char_value   = rx_byte;
                    end
                    else if (field_index_reg >= gprmc_pkg::FIELD_LAT
                             && field_index_reg <= gprmc_pkg::FIELD_EW
                             && fix_reg == gprmc_pkg::FIX_A)
                    begin
                        has_result          = 1'b1;
                        result.kind         = gprmc_pkg::KIND_CHAR;
                        result.field_number = 3'(field_index_reg - 4'd1);
                        result.char_value   = rx_byte;
                    end
                end
            end

            default:
            begin
                phase_next = gprmc_pkg::PH_HUNT1;
            end
        endcase

        // Status result ends the attempt and restarts the hunt
        if (done)
        begin
            has_result        = 1'b1;
            result            = '0;
            result.kind       = gprmc_pkg::KIND_STATUS;
            result.status     = done_status;
            phase_next        = gprmc_pkg::PH_HUNT1;
            fix_next          = gprmc_pkg::FIX_UNKNOWN;
            search_count_next = '0;
            hdr_pos_next      = '0;
            mismatch_next     = 1'b0;
            line_count_next   = '0;
            field_index_next  = '0;
        end
    end

    // State registers advance once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= gprmc_pkg::PH_HUNT1;
            fix_reg          <= gprmc_pkg::FIX_UNKNOWN;
            search_count_reg <= '0;
            hdr_pos_reg      <= '0;
            mismatch_reg     <= 1'b0;
            line_count_reg   <= '0;
            field_index_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            fix_reg          <= fix_next;
            search_count_reg <= search_count_next;
            hdr_pos_reg      <= hdr_pos_next;
            mismatch_reg     <= mismatch_next;
            line_count_reg   <= line_count_next;
            field_index_reg  <= field_index_next;
        end
    end

endmodule

### hdl/gprmc_sentence_field_extractor.sv
// Top level of the GPRMC sentence field extractor: input register, step, result register
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------------
//  in      | in_valid  | in_stall  | rx_byte
//  out     | out_valid | out_stall | result_kind, field_number, char_value,
//          |           |           | sentence_status
//  config  | search_limit_we (no stall) | search_limit_data
//
// One byte per cycle unless the output stalls; a byte's result is registered after the input register.
// The step logic between the input and result registers sets the cycle time.
// Reset (rst_n low) returns to hunting the first dollar sign, search limit 101.
// A stalled result holds; the input stalls only when both registers are full
// and the result is stalled.
`include "gprmc_sentence_field_extractor_macros.svh"

module gprmc_sentence_field_extractor #(
    parameter int MAX_LINE_BYTES = 85
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       result_kind,
    output logic [2:0] field_number,
    output logic [7:0] char_value,
    output logic [1:0] sentence_status,
    input  logic       search_limit_we,
    input  logic [7:0] search_limit_data
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    gprmc_pkg::result_t out_data_reg;
    logic [7:0]         search_limit_reg;

    logic               in_take;
    logic               advance;
    logic               has_result;
    gprmc_pkg::result_t step_result;

    // Handshake control
    assign advance       = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall      = in_valid_reg && !advance;
    assign in_take       = in_valid && !in_stall;
    assign in_valid_next = in_take || (in_valid_reg && !advance);
    assign out_valid_next = (advance && has_result) || (out_valid_reg && out_stall);

    // Search limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            search_limit_reg <= gprmc_pkg::SEARCH_LIMIT_RESET;
        else if (search_limit_we)
            search_limit_reg <= search_limit_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= rx_byte;
    end

    gprmc_step #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .rx_byte      (in_byte_reg),
        .search_limit (search_limit_reg),
        .has_result   (has_result),
        .result       (step_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
            out_data_reg <= step_result;
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = out_data_reg.kind;
    assign field_number    = out_data_reg.field_number;
    assign char_value      = out_data_reg.char_value;
    assign sentence_status = out_data_reg.status;

    // Checks
    `GPRMC_ASSERT_NOW(a_stall_cause, in_stall, in_valid_reg && out_valid_reg && out_stall, "input stalled without output backpressure")
    `GPRMC_ASSERT_NOW(a_status_clean, out_valid && result_kind == gprmc_pkg::KIND_STATUS, field_number == 3'd0 && char_value == 8'd0, "status request carries character data")
    `GPRMC_ASSERT_NOW(a_char_clean, out_valid && result_kind == gprmc_pkg::KIND_CHAR, sentence_status == gprmc_pkg::ST_VALID && field_number <= 3'd5, "character request malformed")
    `GPRMC_ASSERT_NEXT(a_result_lands, advance && has_result, out_valid, "produced request not registered")

endmodule

### bench/testbench.sv
// Self-checking bench for the GPRMC sentence field extractor: directed, limit, receiver hold and random tests
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX      = 85;
    localparam int STUCK_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 4;

    logic       clk;
    logic       rst_n             = 1'b0;
    logic       in_valid          = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte           = 8'h00;
    logic       out_valid;
    logic       out_stall         = 1'b0;
    logic       result_kind;
    logic [2:0] field_number;
    logic [7:0] char_value;
    logic [1:0] sentence_status;
    logic       search_limit_we   = 1'b0;
    logic [7:0] search_limit_data = 8'h00;

    // Idle rates in percent, long receiver hold request
    int snd_idle_pct  = 0;
    int rx_idle_pct   = 0;
    int hold_request  = 0;
    int bytes_sent    = 0;
    int mismatches    = 0;

    // Shadow parser state
    logic [7:0]          limit_reg  = gprmc_pkg::SEARCH_LIMIT_RESET;
    gprmc_pkg::phase_t   ph         = gprmc_pkg::PH_HUNT1;
    logic [7:0]          hunt_count = 8'd0;
    logic [2:0]          hdr_pos    = 3'd0;
    logic                hdr_bad    = 1'b0;
    logic [6:0]          line_len   = 7'd0;
    logic [3:0]          fld        = 4'd0;
    gprmc_pkg::fix_t     fix        = gprmc_pkg::FIX_UNKNOWN;

    // Extracted characters and sentence statuses still to come out
    gprmc_pkg::result_t extracted_q[$];

    gprmc_sentence_field_extractor #(
        .MAX_LINE_BYTES(LINE_MAX)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .field_number     (field_number),
        .char_value       (char_value),
        .sentence_status  (sentence_status),
        .search_limit_we  (search_limit_we),
        .search_limit_data(search_limit_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // End of sentence: queue the status and go back to hunting
    function automatic void close_sentence(input logic [1:0] st);
        extracted_q.push_back(gprmc_pkg::result_t'{kind: gprmc_pkg::KIND_STATUS,
                                                   field_number: 3'd0,
                                                   char_value: 8'd0, status: st});
        ph         = gprmc_pkg::PH_HUNT1;
        hunt_count = 8'd0;
        hdr_pos    = 3'd0;
        hdr_bad    = 1'b0;
        line_len   = 7'd0;
        fld        = 4'd0;
        fix        = gprmc_pkg::FIX_UNKNOWN;
    endfunction

    function automatic void emit_field_char(input logic [2:0] fnum, input logic [7:0] c);
        extracted_q.push_back(gprmc_pkg::result_t'{kind: gprmc_pkg::KIND_CHAR,
                                                   field_number: fnum,
                                                   char_value: c,
                                                   status: gprmc_pkg::ST_VALID});
    endfunction

    // Advance the shadow parser by one accepted byte
    function automatic void parse_rx_byte(input logic [7:0] b);
        // hunting either dollar sign
        if (ph == gprmc_pkg::PH_HUNT1 || ph == gprmc_pkg::PH_HUNT2)
        begin
            if (hunt_count >= limit_reg)
            begin
                close_sentence(gprmc_pkg::ST_HEADER);
                return;
            end
            hunt_count++;
            if (b == gprmc_pkg::CH_DOLLAR)
            begin
                hunt_count = 8'd0;
                if (ph == gprmc_pkg::PH_HUNT1)
                    ph = gprmc_pkg::PH_HUNT2;
                else
                begin
                    ph      = gprmc_pkg::PH_HEADER;
                    hdr_pos = 3'd0;
                    hdr_bad = 1'b0;
                end
            end
            return;
        end
        // talker and sentence id
        if (ph == gprmc_pkg::PH_HEADER)
        begin
            if (b != gprmc_pkg::HDR_TEXT[hdr_pos])
                hdr_bad = 1'b1;
            hdr_pos++;
            if (hdr_pos >= gprmc_pkg::HDR_LEN)
            begin
                if (hdr_bad)
                begin
                    close_sentence(gprmc_pkg::ST_HEADER);
                    return;
                end
                ph       = gprmc_pkg::PH_LINE;
                line_len = 7'd0;
                fld      = 4'd0;
                fix      = gprmc_pkg::FIX_UNKNOWN;
            end
            return;
        end
        // body of the line
        if (b == gprmc_pkg::CH_LF || b == gprmc_pkg::CH_CR)
        begin
            close_sentence((fix == gprmc_pkg::FIX_V && fld >= gprmc_pkg::FIELD_EW)
                           ? gprmc_pkg::ST_VOID : gprmc_pkg::ST_VALID);
            return;
        end
        line_len++;
        if (line_len >= LINE_MAX)
        begin
            close_sentence(gprmc_pkg::ST_NO_END);
            return;
        end
        if (b == gprmc_pkg::CH_COMMA)
        begin
            if (fld < gprmc_pkg::FIELD_MAX)
                fld++;
            return;
        end
        if (fld == gprmc_pkg::FIELD_TIME)
            emit_field_char(gprmc_pkg::FNUM_TIME, b);
        else if (fld == gprmc_pkg::FIELD_STAT)
        begin
            if (fix == gprmc_pkg::FIX_UNKNOWN)
                fix = (b == gprmc_pkg::CH_A) ? gprmc_pkg::FIX_A
                    : (b == gprmc_pkg::CH_V) ? gprmc_pkg::FIX_V : gprmc_pkg::FIX_OTHER;
            emit_field_char(gprmc_pkg::FNUM_STAT, b);
        end
        else if (fld >= gprmc_pkg::FIELD_LAT && fld <= gprmc_pkg::FIELD_EW
                 && fix == gprmc_pkg::FIX_A)
            emit_field_char(3'(fld - 4'd1), b);
    endfunction

    // Any byte except a dollar sign
    function automatic logic [7:0] junk_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == gprmc_pkg::CH_DOLLAR)
            c = 8'h25;
        return c;
    endfunction

    // Field content: mostly digits and dots, sometimes any non-separator byte
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        if ($urandom_range(9) < 7)
            c = 8'($urandom_range(8'h39, 8'h2E));
        else
        begin
            c = 8'($urandom_range(255));
            if (c == gprmc_pkg::CH_COMMA || c == gprmc_pkg::CH_CR || c == gprmc_pkg::CH_LF)
                c = 8'h3F;
        end
        return c;
    endfunction

    // Offer one byte, wait for acceptance, then predict
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Stop offering and let every outstanding request come out
    task automatic drain_extractor();
        in_valid <= 1'b0;
        while (extracted_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_search_limit(input logic [7:0] v);
        search_limit_we   <= 1'b1;
        search_limit_data <= v;
        @(posedge clk);
        search_limit_we   <= 1'b0;
        limit_reg = v;
    endtask

    // Fix valid, void fix, unknown status, header failure, saturation, byte extremes
    task automatic test_directed_sentences();
        send_text("$$GPRMC,");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("$,A,4,N,5,W\n");
        send_text("$$GPRMC,1,V,,,,,\r");
        send_text("$$GPRMC,1,V\n");
        send_text("$$GPRMC,,X,7\r");
        send_text("$$GPRMX");
        send_text("$$GPRMC\n");
        send_text("$$GPRMC,,,,,,,,,,,,,,,,9\r");
    endtask

    // Hunt timeout at a limit of 1 and of 255; a dollar sign past the limit still fails
    task automatic test_search_limit();
        drain_extractor();
        set_search_limit(8'd1);
        send_text("$x$");
        send_text("$$GPRMC,7,A\r");
        drain_extractor();
        set_search_limit(8'd255);
        repeat (255) send_byte(junk_byte());
        send_byte(gprmc_pkg::CH_DOLLAR);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_receiver_hold();
        int saved_pct;
        saved_pct    = snd_idle_pct;
        snd_idle_pct = 0;
        hold_request = HOLD_CYCLES;
        send_text("$$GPRMC,");
        repeat (30) send_byte(field_char());
        send_text(",A\n");
        snd_idle_pct = saved_pct;
    endtask

    // Mostly well-formed sentences with random content, plus noise and broken ones
    task automatic test_random_traffic(input int n_bytes);
        int stop_at;
        int pick;
        int n;
        int bad_pos;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                n = $urandom_range(20, 1);
                repeat (n) send_byte(8'($urandom_range(255)));
            end
            else if (pick < 12)
            begin
                // run a hunt past its limit
                if (limit_reg < 64 || $urandom_range(7) == 0)
                begin
                    if ($urandom_range(1) == 1)
                        send_byte(gprmc_pkg::CH_DOLLAR);
                    repeat (int'(limit_reg) + 1) send_byte(junk_byte());
                end
            end
            else if (pick < 16)
            begin
                // long line, mostly with no end in time
                send_text("$$GPRMC,");
                n = $urandom_range(95, LINE_MAX - 4);
                repeat (n) send_byte(field_char());
                send_byte(gprmc_pkg::CH_LF);
            end
            else
            begin
                repeat ($urandom_range(3)) send_byte(junk_byte());
                send_byte(gprmc_pkg::CH_DOLLAR);
                repeat ($urandom_range(2)) send_byte(junk_byte());
                send_byte(gprmc_pkg::CH_DOLLAR);
                bad_pos = ($urandom_range(15) == 0) ? $urandom_range(4) : gprmc_pkg::HDR_LEN;
                for (int i = 0; i < gprmc_pkg::HDR_LEN; i++)
                    send_byte((i == bad_pos)
                              ? (gprmc_pkg::HDR_TEXT[i] ^ 8'($urandom_range(255, 1)))
                              : gprmc_pkg::HDR_TEXT[i]);
                repeat ($urandom_range(2)) send_byte(field_char());
                n = ($urandom_range(7) == 0) ? $urandom_range(17, 8) : $urandom_range(7);
                for (int f = 1; f <= n; f++)
                begin
                    send_byte(gprmc_pkg::CH_COMMA);
                    if (f == gprmc_pkg::FIELD_STAT)
                    begin
                        pick = $urandom_range(9);
                        if (pick < 4)
                            send_byte(gprmc_pkg::CH_A);
                        else if (pick < 7)
                            send_byte(gprmc_pkg::CH_V);
                        else if (pick < 8)
                            send_byte(field_char());
                        repeat ($urandom_range(1)) send_byte(field_char());
                    end
                    else
                        repeat ($urandom_range(6)) send_byte(field_char());
                end
                // terminate with CR or LF, or now and then leave the line open
                pick = $urandom_range(9);
                if (pick < 5)
                    send_byte(gprmc_pkg::CH_CR);
                else if (pick < 9)
                    send_byte(gprmc_pkg::CH_LF);
            end
        end
    endtask

    // Result side: compare accepted requests, then drive stall
    initial
    begin : result_monitor
        gprmc_pkg::result_t want;
        int                 hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (extracted_q.size() == 0)
                begin
                    $display("%0t: unexpected request kind %0d field %0d char %h status %0d",
                             $time, result_kind, field_number, char_value, sentence_status);
                    mismatches++;
                end
                else
                begin
                    want = extracted_q.pop_front();
                    if (result_kind !== want.kind)
                    begin
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, want.kind, result_kind);
                        mismatches++;
                    end
                    if (field_number !== want.field_number)
                    begin
                        $display("%0t: field_number expected %0d actual %0d",
                                 $time, want.field_number, field_number);
                        mismatches++;
                    end
                    if (char_value !== want.char_value)
                    begin
                        $display("%0t: char_value expected %h actual %h",
                                 $time, want.char_value, char_value);
                        mismatches++;
                    end
                    if (sentence_status !== want.status)
                    begin
                        $display("%0t: sentence_status expected %0d actual %0d",
                                 $time, want.status, sentence_status);
                        mismatches++;
                    end
                end
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Watchdog: too many cycles with no request moving on either side
    initial
    begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = 10;
        rx_idle_pct  = 76;
        test_directed_sentences();
        test_search_limit();
        test_random_traffic(700);

        drain_extractor();
        set_search_limit(8'($urandom_range(30, 2)));
        snd_idle_pct = 76;
        rx_idle_pct  = 10;
        test_receiver_hold();
        test_random_traffic(700);

        drain_extractor();
        set_search_limit(gprmc_pkg::SEARCH_LIMIT_RESET);
        snd_idle_pct = 0;
        rx_idle_pct  = 0;
        test_random_traffic(600);

        drain_extractor();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
